/* design/bfgl_pkg.sv */
// Package for the bitmap font glyph layout block: command codes, line break codes,
// glyph store geometry, the stored glyph entry type and address helpers.
// Depends on nothing; every other design file but bfgl_if imports it.
package bfgl_pkg;

   localparam int GLYPH_ENTRIES = 256;
   localparam int GLYPH_ADDR_W  = $clog2(GLYPH_ENTRIES);

   localparam logic [1:0] CMD_LOAD_GLYPH   = 2'd0;
   localparam logic [1:0] CMD_CLEAR_GLYPHS = 2'd1;
   localparam logic [1:0] CMD_BEGIN_TEXT   = 2'd2;
   localparam logic [1:0] CMD_TEXT_CHAR    = 2'd3;

   localparam logic [7:0] CODE_CR = 8'd13;
   localparam logic [7:0] CODE_LF = 8'd10;

   // One glyph store entry, 120 bits.
   typedef struct packed {
      logic [15:0] atlas_x;
      logic [15:0] atlas_y;
      logic [15:0] glyph_width;
      logic [15:0] glyph_height;
      logic [15:0] offset_x;
      logic [15:0] offset_y;
      logic [15:0] advance_x;
      logic [7:0]  page_index;
   } glyph_entry_type;

   // The item held between the store read and the placement stage.
   typedef struct packed {
      logic       valid;
      logic [1:0] command;
      logic [7:0] code;
      logic       hit;
   } stage_type;

   function automatic logic [GLYPH_ADDR_W-1:0] glyph_addr(input logic [7:0] code);
      logic [GLYPH_ADDR_W+7:0] wide;
      wide = {{GLYPH_ADDR_W{1'b0}}, code};
      return wide[GLYPH_ADDR_W-1:0];
   endfunction

   function automatic logic glyph_in_range(input logic [7:0] code);
      return ({24'd0, code} < 32'(GLYPH_ENTRIES));
   endfunction

endpackage

/* design/bfgl_if.sv */
// Channel interfaces of the bitmap font glyph layout block: request, response and
// the line height register write channel. Valid/ready handshake on each.
// Depends on nothing.
interface bfgl_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        command;
   logic [7:0]        char_code;
   logic [15:0]       atlas_x;
   logic [15:0]       atlas_y;
   logic [15:0]       glyph_width;
   logic [15:0]       glyph_height;
   logic signed [15:0] offset_x;
   logic signed [15:0] offset_y;
   logic signed [15:0] advance_x;
   logic [7:0]        page_index;

   modport source (output valid, command, char_code, atlas_x, atlas_y, glyph_width,
                   glyph_height, offset_x, offset_y, advance_x, page_index,
                   input ready);
   modport sink   (input valid, command, char_code, atlas_x, atlas_y, glyph_width,
                   glyph_height, offset_x, offset_y, advance_x, page_index,
                   output ready);
endinterface

interface bfgl_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         placed_code;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic [15:0]        out_width;
   logic [15:0]        out_height;
   logic [7:0]         out_page;
   logic [15:0]        src_x;
   logic [15:0]        src_y;

   modport source (output valid, placed_code, pos_x, pos_y, out_width, out_height,
                   out_page, src_x, src_y, input ready);
   modport sink   (input valid, placed_code, pos_x, pos_y, out_width, out_height,
                   out_page, src_x, src_y, output ready);
endinterface

interface bfgl_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] line_height;

   modport source (output valid, line_height, input ready);
   modport sink   (input valid, line_height, output ready);
endinterface

/* design/bfgl_glyph_store.sv */
// Glyph store: a memory of glyph entries indexed by character code, plus one valid
// flip-flop per entry. Writes and reads happen at the edge an item is accepted.
// Depends on bfgl_pkg.
module bfgl_glyph_store (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [1:0]               command,
   input  logic [7:0]               code,
   input  bfgl_pkg::glyph_entry_type wr_entry,
   output bfgl_pkg::glyph_entry_type rd_entry,
   output logic                     rd_hit
);
   import bfgl_pkg::*;

   glyph_entry_type           glyph_mem [GLYPH_ENTRIES];
   logic [GLYPH_ENTRIES-1:0]  valid_ff;
   glyph_entry_type           rd_entry_ff;
   logic                      rd_hit_ff;
   logic [GLYPH_ADDR_W-1:0]   addr;
   logic                      in_range;
   logic                      load_hit;

   assign addr     = glyph_addr(code);
   assign in_range = glyph_in_range(code);
   assign load_hit = accept && (command == CMD_LOAD_GLYPH) && in_range;

   always_ff @(posedge clock) begin
      if (load_hit) begin
         glyph_mem[addr] <= wr_entry;
      end
      if (accept) begin
         rd_entry_ff <= glyph_mem[addr];
         rd_hit_ff   <= valid_ff[addr] && in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (load_hit) begin
         valid_ff[addr] <= 1'b1;
      end else if (accept && (command == CMD_CLEAR_GLYPHS)) begin
         valid_ff <= '0;
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_hit   = rd_hit_ff;

   a_clear_drops_all: assert property (@(posedge clock) disable iff (reset)
      accept && (command == CMD_CLEAR_GLYPHS) |=> (valid_ff == '0))
      else $error("valid marks survived a clear");

   a_load_marks_valid: assert property (@(posedge clock) disable iff (reset)
      load_hit |=> valid_ff[$past(addr)])
      else $error("loaded glyph not marked valid");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      accept |=> (!rd_hit_ff || $past(in_range)))
      else $error("hit reported for a code beyond the store");

endmodule

/* design/bfgl_placer.sv */
// Placement stage: holds the pen, handles line breaks and begin_text, adds the
// glyph offset to the pen with saturation and keeps the result register.
// Depends on bfgl_pkg and bfgl_rsp_if.
module bfgl_placer (
   input  logic                     clock,
   input  logic                     reset,
   input  bfgl_pkg::stage_type      stage,
   input  bfgl_pkg::glyph_entry_type entry,
   input  logic [15:0]              line_height,
   output logic                     stage_done,
   bfgl_rsp_if.source               rsp_bus
);
   import bfgl_pkg::*;

   logic [15:0] pen_x_ff, pen_x_in;
   logic [15:0] pen_y_ff, pen_y_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_code_ff;
   logic [15:0] out_pos_x_ff, out_pos_y_ff;
   logic [15:0] out_width_ff, out_height_ff, out_src_x_ff, out_src_y_ff;
   logic [7:0]  out_page_ff;

   logic        is_break;
   logic        produce;
   logic [16:0] pos_x_sum, pos_y_sum, adv_sum;
   logic [17:0] line_sum;
   logic [15:0] pos_x_sat, pos_y_sat, adv_sat, line_sat;

   function automatic logic [15:0] sat17(input logic [16:0] sum);
      logic [15:0] res;
      if (sum[16] != sum[15]) begin
         res = sum[16] ? 16'h8000 : 16'h7FFF;
      end else begin
         res = sum[15:0];
      end
      return res;
   endfunction

   assign is_break = (stage.code == CODE_CR) || (stage.code == CODE_LF);
   assign produce  = stage.valid && (stage.command == CMD_TEXT_CHAR) && !is_break
                     && stage.hit;
   assign stage_done = stage.valid && (!produce || !out_valid_ff || rsp_bus.ready);

   assign pos_x_sum = {pen_x_ff[15], pen_x_ff} + {entry.offset_x[15], entry.offset_x};
   assign pos_y_sum = {pen_y_ff[15], pen_y_ff} + {entry.offset_y[15], entry.offset_y};
   assign adv_sum   = {pen_x_ff[15], pen_x_ff} + {entry.advance_x[15], entry.advance_x};
   assign line_sum  = {{2{pen_y_ff[15]}}, pen_y_ff} + {2'b00, line_height};
   assign pos_x_sat = sat17(pos_x_sum);
   assign pos_y_sat = sat17(pos_y_sum);
   assign adv_sat   = sat17(adv_sum);
   // Adding an unsigned height can only overflow upwards.
   assign line_sat  = (!line_sum[17] && (line_sum[16:15] != 2'b00)) ? 16'h7FFF
                                                                    : line_sum[15:0];

   always_comb begin
      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      if (stage_done) begin
         unique case (stage.command)
            CMD_BEGIN_TEXT: begin
               pen_x_in = '0;
               pen_y_in = '0;
            end
            CMD_TEXT_CHAR: begin
               if (is_break) begin
                  pen_x_in = '0;
                  pen_y_in = line_sat;
               end else if (stage.hit) begin
                  pen_x_in = adv_sat;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign out_valid_in = (stage_done && produce) || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_done && produce) begin
         out_code_ff   <= stage.code;
         out_pos_x_ff  <= pos_x_sat;
         out_pos_y_ff  <= pos_y_sat;
         out_width_ff  <= entry.glyph_width;
         out_height_ff <= entry.glyph_height;
         out_page_ff   <= entry.page_index;
         out_src_x_ff  <= entry.atlas_x;
         out_src_y_ff  <= entry.atlas_y;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.placed_code = out_code_ff;
   assign rsp_bus.pos_x       = out_pos_x_ff;
   assign rsp_bus.pos_y       = out_pos_y_ff;
   assign rsp_bus.out_width   = out_width_ff;
   assign rsp_bus.out_height  = out_height_ff;
   assign rsp_bus.out_page    = out_page_ff;
   assign rsp_bus.src_x       = out_src_x_ff;
   assign rsp_bus.src_y       = out_src_y_ff;

   a_begin_zeroes_pen: assert property (@(posedge clock) disable iff (reset)
      stage_done && (stage.command == CMD_BEGIN_TEXT) |=> (pen_x_ff == '0) && (pen_y_ff == '0))
      else $error("pen not at origin after begin_text");

   a_break_returns_x: assert property (@(posedge clock) disable iff (reset)
      stage_done && (stage.command == CMD_TEXT_CHAR) && is_break |=> (pen_x_ff == '0))
      else $error("pen x not reset by a line break");

endmodule

/* design/bitmap_font_glyph_layout.sv */
// Top level of the bitmap font glyph layout block: input handshake, line height
// register, and the glyph store and placement stages.
// Depends on bfgl_pkg, bfgl_if, bfgl_glyph_store and bfgl_placer.
//
//   Channel   Direction  Carries
//   req_bus   in         command, char_code and the glyph fields for load_glyph
//   rsp_bus   out        one placed glyph per non-break text character with a valid glyph
//   csr_bus   in         line_height write data, always ready
//
// One item is accepted per cycle when nothing stalls. The glyph store is written or
// read at the accepting edge and the placement stage then loads the result register,
// from which the placed glyph is offered.
// A full result register that is not taken holds the next producing text item in
// the placement stage, and only then does the request channel stall.
// Reset is synchronous and clears all valid marks at once; the glyph memory is not.
module bitmap_font_glyph_layout (
   input  logic       clock,
   input  logic       reset,
   bfgl_req_if.sink   req_bus,
   bfgl_rsp_if.source rsp_bus,
   bfgl_csr_if.sink   csr_bus
);
   import bfgl_pkg::*;

   logic            accept;
   logic            stage_done;
   logic            s1_valid_ff, s1_valid_in;
   logic [1:0]      s1_command_ff;
   logic [7:0]      s1_code_ff;
   logic [15:0]     line_height_ff;
   glyph_entry_type wr_entry;
   glyph_entry_type rd_entry;
   logic            rd_hit;
   stage_type       stage;

   // The placement stage is free when empty or when its item leaves this cycle,
   // which keeps the request side moving at one item per cycle unless a held result stalls it.
   assign req_bus.ready = !s1_valid_ff || stage_done;
   assign accept        = req_bus.valid && req_bus.ready;

   // The register port never stalls; writes must only happen while the block is idle, which the block does not enforce.
   assign csr_bus.ready = 1'b1;

   assign wr_entry.atlas_x      = req_bus.atlas_x;
   assign wr_entry.atlas_y      = req_bus.atlas_y;
   assign wr_entry.glyph_width  = req_bus.glyph_width;
   assign wr_entry.glyph_height = req_bus.glyph_height;
   assign wr_entry.offset_x     = req_bus.offset_x;
   assign wr_entry.offset_y     = req_bus.offset_y;
   assign wr_entry.advance_x    = req_bus.advance_x;
   assign wr_entry.page_index   = req_bus.page_index;

   assign s1_valid_in = accept || (s1_valid_ff && !stage_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         line_height_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            line_height_ff <= csr_bus.line_height;
         end
      end
   end

   // Item fields needed by the placement stage travel alongside the store read.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_command_ff <= req_bus.command;
         s1_code_ff    <= req_bus.char_code;
      end
   end

   bfgl_glyph_store u_store (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .command  (req_bus.command),
      .code     (req_bus.char_code),
      .wr_entry (wr_entry),
      .rd_entry (rd_entry),
      .rd_hit   (rd_hit)
   );

   assign stage.valid   = s1_valid_ff;
   assign stage.command = s1_command_ff;
   assign stage.code    = s1_code_ff;
   assign stage.hit     = rd_hit;

   bfgl_placer u_placer (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .entry       (rd_entry),
      .line_height (line_height_ff),
      .stage_done  (stage_done),
      .rsp_bus     (rsp_bus)
   );

endmodule

/* tb/bitmap_font_glyph_layout_test.sv */
// Self-checking testbench for the bitmap font glyph layout block: directed and
// random command streams with an in-house predictor of glyph store and pen.
// Depends on bfgl_pkg, the bfgl channel interfaces and bitmap_font_glyph_layout.
`timescale 1ns / 100ps

module bitmap_font_glyph_layout_test;
   import bfgl_pkg::*;

   // One request item as the testbench builds it, and one placed glyph.
   typedef struct {
      logic [1:0]         command;
      logic [7:0]         char_code;
      logic [15:0]        atlas_x;
      logic [15:0]        atlas_y;
      logic [15:0]        glyph_width;
      logic [15:0]        glyph_height;
      logic signed [15:0] offset_x;
      logic signed [15:0] offset_y;
      logic signed [15:0] advance_x;
      logic [7:0]         page_index;
   } glyph_request_type;

   typedef struct {
      logic [7:0]         placed_code;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [15:0]        out_width;
      logic [15:0]        out_height;
      logic [7:0]         out_page;
      logic [15:0]        src_x;
      logic [15:0]        src_y;
   } placed_glyph_type;

   // The scoreboard keeps its own glyph table, valid marks, pen and line height.
   // Every accepted request updates them in acceptance order, and each text item
   // that hits a loaded glyph queues the placement that the block must return.
   class glyph_layout_board_type;
      glyph_entry_type  glyph_table [GLYPH_ENTRIES];
      bit               glyph_loaded [GLYPH_ENTRIES];
      int               pen_x;
      int               pen_y;
      int               line_height;
      placed_glyph_type awaited [$];
      int               errors;

      function new();
         foreach (glyph_loaded[i]) glyph_loaded[i] = 1'b0;
         pen_x = 0;
         pen_y = 0;
         line_height = 0;
         errors = 0;
      endfunction

      static function int clamp_s16(int v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function void set_line_height(logic [15:0] v);
         line_height = int'(v);
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void note_request(glyph_request_type r);
         glyph_entry_type  g;
         placed_glyph_type p;
         case (r.command)
            CMD_LOAD_GLYPH: begin
               // Codes beyond the store are dropped; with a full-size store none are.
               if (int'(r.char_code) < GLYPH_ENTRIES) begin
                  g.atlas_x      = r.atlas_x;
                  g.atlas_y      = r.atlas_y;
                  g.glyph_width  = r.glyph_width;
                  g.glyph_height = r.glyph_height;
                  g.offset_x     = r.offset_x;
                  g.offset_y     = r.offset_y;
                  g.advance_x    = r.advance_x;
                  g.page_index   = r.page_index;
                  glyph_table[r.char_code]  = g;
                  glyph_loaded[r.char_code] = 1'b1;
               end
            end
            CMD_CLEAR_GLYPHS: begin
               foreach (glyph_loaded[i]) glyph_loaded[i] = 1'b0;
            end
            CMD_BEGIN_TEXT: begin
               pen_x = 0;
               pen_y = 0;
            end
            CMD_TEXT_CHAR: begin
               // A line break wins over any glyph loaded for that code.
               if (r.char_code == CODE_CR || r.char_code == CODE_LF) begin
                  pen_x = 0;
                  pen_y = clamp_s16(pen_y + line_height);
               end else if (int'(r.char_code) < GLYPH_ENTRIES &&
                            glyph_loaded[r.char_code]) begin
                  g = glyph_table[r.char_code];
                  p.placed_code = r.char_code;
                  p.pos_x       = 16'(clamp_s16(pen_x + int'($signed(g.offset_x))));
                  p.pos_y       = 16'(clamp_s16(pen_y + int'($signed(g.offset_y))));
                  p.out_width   = g.glyph_width;
                  p.out_height  = g.glyph_height;
                  p.out_page    = g.page_index;
                  p.src_x       = g.atlas_x;
                  p.src_y       = g.atlas_y;
                  awaited = {awaited, p};
                  pen_x = clamp_s16(pen_x + int'($signed(g.advance_x)));
               end
            end
         endcase
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(placed_glyph_type got);
         placed_glyph_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected placed glyph, expected none, got code %h at %h,%h",
                     $time, got.placed_code, got.pos_x, got.pos_y);
            errors++;
            return;
         end
         want = awaited.pop_front();
         check_field("placed_code", 16'(want.placed_code), 16'(got.placed_code));
         check_field("pos_x", want.pos_x, got.pos_x);
         check_field("pos_y", want.pos_y, got.pos_y);
         check_field("out_width", want.out_width, got.out_width);
         check_field("out_height", want.out_height, got.out_height);
         check_field("out_page", 16'(want.out_page), 16'(got.out_page));
         check_field("src_x", want.src_x, got.src_x);
         check_field("src_y", want.src_y, got.src_y);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   bfgl_req_if req_bus ();
   bfgl_rsp_if rsp_bus ();
   bfgl_csr_if csr_bus ();

   bitmap_font_glyph_layout dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   glyph_layout_board_type board;

   // When set, the request side sends back to back with no gaps at all.
   bit tx_steady;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gap lengths: mostly none, often short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offsets lean towards small values so that text runs look like text, but the
   // extremes and fully random values turn up often enough to drive saturation.
   function automatic logic signed [15:0] rand_offset();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return -16'sd1;
            default: return 16'sd0;
         endcase
      end
      if (roll < 40) return 16'($urandom);
      return 16'($urandom_range(0, 60) - 20);
   endfunction

   // Advances are mostly small and positive, so the pen walks across the line.
   function automatic logic signed [15:0] rand_advance();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return 16'sh8000;
      if (roll < 10) return 16'sh7FFF;
      if (roll < 25) return 16'($urandom);
      return 16'($urandom_range(0, 24));
   endfunction

   // Random items concentrate on a small set of codes so that loaded glyphs are
   // hit often; the set includes the carriage return code and both ends of the range.
   // All payload fields are random whatever the command, as the block must
   // ignore them outside a glyph load.
   function automatic glyph_request_type random_request();
      glyph_request_type r;
      logic [7:0]        hot_codes [0:11];
      int                roll;
      hot_codes = '{8'd0, 8'd1, 8'd13, 8'd32, 8'd65, 8'd66, 8'd97, 8'd127,
                    8'd128, 8'd200, 8'd254, 8'd255};
      roll = $urandom_range(0, 99);
      if (roll < 25)      r.command = CMD_LOAD_GLYPH;
      else if (roll < 28) r.command = CMD_CLEAR_GLYPHS;
      else if (roll < 34) r.command = CMD_BEGIN_TEXT;
      else                r.command = CMD_TEXT_CHAR;
      roll = $urandom_range(0, 99);
      if (r.command == CMD_TEXT_CHAR && roll >= 70 && roll < 80)
         r.char_code = roll[0] ? CODE_CR : CODE_LF;
      else if (roll < 75)
         r.char_code = hot_codes[$urandom_range(0, 11)];
      else
         r.char_code = 8'($urandom);
      r.atlas_x      = 16'($urandom);
      r.atlas_y      = 16'($urandom);
      r.glyph_width  = 16'($urandom);
      r.glyph_height = 16'($urandom);
      r.offset_x     = rand_offset();
      r.offset_y     = rand_offset();
      r.advance_x    = rand_advance();
      r.page_index   = 8'($urandom);
      return r;
   endfunction

   // A command with random payload, for the directed part.
   function automatic glyph_request_type command_item(logic [1:0] cmd, logic [7:0] code);
      glyph_request_type r;
      r = random_request();
      r.command   = cmd;
      r.char_code = code;
      return r;
   endfunction

   function automatic glyph_request_type load_item(
      logic [7:0] code, logic [15:0] ax, logic [15:0] ay, logic [15:0] w, logic [15:0] h,
      logic signed [15:0] ox, logic signed [15:0] oy, logic signed [15:0] adv,
      logic [7:0] page);
      glyph_request_type r;
      r.command      = CMD_LOAD_GLYPH;
      r.char_code    = code;
      r.atlas_x      = ax;
      r.atlas_y      = ay;
      r.glyph_width  = w;
      r.glyph_height = h;
      r.offset_x     = ox;
      r.offset_y     = oy;
      r.advance_x    = adv;
      r.page_index   = page;
      return r;
   endfunction

   // Presents one item after an optional gap and holds it until it is taken.
   // Valid is only ever lowered during a gap, never within the step in which
   // the next item is raised.
   task automatic send_request(input glyph_request_type r);
      int gap;
      gap = tx_steady ? 0 : pick_gap();
      repeat (gap) @(negedge clock) req_bus.valid = 1'b0;
      @(negedge clock);
      req_bus.valid        = 1'b1;
      req_bus.command      = r.command;
      req_bus.char_code    = r.char_code;
      req_bus.atlas_x      = r.atlas_x;
      req_bus.atlas_y      = r.atlas_y;
      req_bus.glyph_width  = r.glyph_width;
      req_bus.glyph_height = r.glyph_height;
      req_bus.offset_x     = r.offset_x;
      req_bus.offset_y     = r.offset_y;
      req_bus.advance_x    = r.advance_x;
      req_bus.page_index   = r.page_index;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(r);
   endtask

   // The register is only written while the block is idle, so the scoreboard
   // can take the new height at the handshake edge.
   task automatic write_line_height(input logic [15:0] v);
      @(negedge clock);
      csr_bus.valid       = 1'b1;
      csr_bus.line_height = v;
      do @(posedge clock); while (!csr_bus.ready);
      board.set_line_height(v);
      @(negedge clock) csr_bus.valid = 1'b0;
   endtask

   // Waits for every awaited glyph, then lets a line break or a miss that is
   // still in the two-stage pipeline settle before anything else happens.
   task automatic wait_idle();
      @(negedge clock) req_bus.valid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Result side back-pressure: long stretches of steady ready, otherwise short
   // bursts of ready broken by stalls of mostly short and sometimes long length.
   initial begin : result_stalls
      int n;
      rsp_bus.ready = 1'b0;
      forever begin
         if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(30, 80);
            repeat (n) @(negedge clock) rsp_bus.ready = 1'b1;
         end else begin
            n = $urandom_range(1, 6);
            repeat (n) @(negedge clock) rsp_bus.ready = 1'b1;
            n = pick_gap();
            repeat (n) @(negedge clock) rsp_bus.ready = 1'b0;
         end
      end
   end

   // Every result taken at a rising edge is checked against the oldest
   // expectation; the values are those held just before the edge.
   always @(posedge clock) begin : take_result
      placed_glyph_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.placed_code = rsp_bus.placed_code;
         got.pos_x       = rsp_bus.pos_x;
         got.pos_y       = rsp_bus.pos_y;
         got.out_width   = rsp_bus.out_width;
         got.out_height  = rsp_bus.out_height;
         got.out_page    = rsp_bus.out_page;
         got.src_x       = rsp_bus.src_x;
         got.src_y       = rsp_bus.src_y;
         board.check_result(got);
      end
   end

   initial begin : stimulus
      logic [15:0] phase_height [0:4];
      int          n;
      board = new();
      tx_steady = 1'b0;
      req_bus.valid        = 1'b0;
      req_bus.command      = CMD_LOAD_GLYPH;
      req_bus.char_code    = 8'd0;
      req_bus.atlas_x      = 16'd0;
      req_bus.atlas_y      = 16'd0;
      req_bus.glyph_width  = 16'd0;
      req_bus.glyph_height = 16'd0;
      req_bus.offset_x     = 16'sd0;
      req_bus.offset_y     = 16'sd0;
      req_bus.advance_x    = 16'sd0;
      req_bus.page_index   = 8'd0;
      csr_bus.valid        = 1'b0;
      csr_bus.line_height  = 16'd0;

      repeat (12) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // Directed part. The largest line height makes the first line break push
      // pen y straight into saturation.
      write_line_height(16'hFFFF);
      // A text item before anything is loaded must give nothing.
      send_request(command_item(CMD_TEXT_CHAR, 8'd65));
      // Code zero with every field at its top and the most negative offsets.
      send_request(load_item(8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'sh8000, 16'sh8000, 16'sh7FFF, 8'hFF));
      // Code 255 with every field at zero and the most positive offsets.
      send_request(load_item(8'd255, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                             16'sh7FFF, 16'sh7FFF, 16'sh8000, 8'h00));
      // A glyph for carriage return, which must never be placed.
      send_request(load_item(CODE_CR, 16'd5, 16'd6, 16'd7, 16'd8,
                             16'sd1, 16'sd1, 16'sd4, 8'd3));
      send_request(load_item(8'd65, 16'd100, 16'd200, 16'd8, 16'd12,
                             -16'sd2, 16'sd3, 16'sd9, 8'd1));
      // Pen x runs into the top limit, then the glyph position does, then pen x
      // runs into the bottom limit twice over.
      send_request(command_item(CMD_TEXT_CHAR, 8'd0));
      send_request(command_item(CMD_TEXT_CHAR, 8'd0));
      send_request(command_item(CMD_TEXT_CHAR, 8'd255));
      send_request(command_item(CMD_TEXT_CHAR, 8'd255));
      send_request(command_item(CMD_TEXT_CHAR, 8'd255));
      // Line breaks with a saturated pen y, and a position at the top y limit.
      send_request(command_item(CMD_TEXT_CHAR, CODE_CR));
      send_request(command_item(CMD_TEXT_CHAR, 8'd0));
      send_request(command_item(CMD_TEXT_CHAR, 8'd255));
      send_request(command_item(CMD_TEXT_CHAR, CODE_LF));
      send_request(command_item(CMD_BEGIN_TEXT, 8'($urandom)));
      send_request(command_item(CMD_TEXT_CHAR, 8'd65));
      send_request(command_item(CMD_TEXT_CHAR, CODE_LF));
      // After a clear nothing is placed until a glyph is loaded again.
      send_request(command_item(CMD_CLEAR_GLYPHS, 8'($urandom)));
      send_request(command_item(CMD_TEXT_CHAR, 8'd65));
      send_request(command_item(CMD_TEXT_CHAR, 8'd0));
      send_request(load_item(8'd65, 16'h1234, 16'hABCD, 16'd9, 16'd14,
                             16'sd0, -16'sd7, 16'sd10, 8'h80));
      send_request(command_item(CMD_TEXT_CHAR, 8'd65));
      send_request(command_item(CMD_TEXT_CHAR, 8'd1));
      wait_idle();

      // Random part in five phases, each with its own line height, the
      // register being rewritten only once the block has gone quiet.
      phase_height[0] = 16'd0;
      phase_height[1] = 16'd7;
      phase_height[2] = 16'($urandom);
      phase_height[3] = 16'd1000;
      phase_height[4] = 16'hFFFF;
      for (int phase = 0; phase < 5; phase++) begin
         write_line_height(phase_height[phase]);
         for (n = 0; n < 110; n++) begin
            if (n % 40 == 0) tx_steady = ($urandom_range(0, 2) == 0);
            send_request(random_request());
         end
         wait_idle();
      end

      if (board.pending() != 0) begin
         $display("%0t: %0d placed glyphs expected but never returned",
                  $time, board.pending());
         board.errors++;
      end
      if (board.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run, with every gap and stall long.
   initial begin : watchdog
      #5_000_000;
      $display("%0t: run timed out", $time);
      $display("Some tests failed");
      $finish;
   end

endmodule
